/* src/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, constants and the microcode program of the scalar Kalman
// time filter.
// ----------------------------------------------------------------------------
package skt_pkg;

    // default number of fraction bits of the covariance and gain
    localparam int FRAC_BITS_DEF = 24;

    // microcode address width
    localparam int PC_W = 5;

    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef logic [PC_W-1:0] pc_t;

    // datapath micro-operations
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_LOAD,
        UOP_PRED,
        UOP_DIV,
        UOP_WB_DIV,
        UOP_MUL_AA,
        UOP_MUL_AC,
        UOP_WB_MUL,
        UOP_GAIN_BP,
        UOP_GAIN_DEN,
        UOP_DIFF,
        UOP_MUL_DK,
        UOP_UPDATE,
        UOP_EMIT
    } uop_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_IN,
        COND_FIRST,
        COND_EZERO,
        COND_BUSY,
        COND_OUT_BUSY
    } cond_t;

    // one control word
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        pc_t   target;
    } ctl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_fire;
        logic first;
        logic ezero;
        logic busy;
        logic out_busy;
    } stat_t;

    // program labels
    localparam pc_t PC_IDLE     = 5'd0;
    localparam pc_t PC_FIRST    = 5'd1;
    localparam pc_t PC_PRED     = 5'd2;
    localparam pc_t PC_DIV_A    = 5'd3;
    localparam pc_t PC_WB_A     = 5'd4;
    localparam pc_t PC_MUL_AA   = 5'd5;
    localparam pc_t PC_WB_AA    = 5'd6;
    localparam pc_t PC_MUL_AC   = 5'd7;
    localparam pc_t PC_WB_AC    = 5'd8;
    localparam pc_t PC_GAIN_BP  = 5'd9;
    localparam pc_t PC_GAIN_DEN = 5'd10;
    localparam pc_t PC_DIV_K    = 5'd11;
    localparam pc_t PC_WB_K     = 5'd12;
    localparam pc_t PC_DIFF     = 5'd13;
    localparam pc_t PC_MUL_DK   = 5'd14;
    localparam pc_t PC_WB_DK    = 5'd15;
    localparam pc_t PC_UPDATE   = 5'd16;
    localparam pc_t PC_LOAD     = 5'd17;
    localparam pc_t PC_EMIT     = 5'd18;
    localparam pc_t PC_RET      = 5'd19;

    // microcode rom
    function automatic ctl_t ucode(input pc_t pc);
        ctl_t w;
        w = '{op: UOP_NOP, cond: COND_ALWAYS, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:     w = '{op: UOP_ACCEPT,   cond: COND_NO_IN,    target: PC_IDLE};
            PC_FIRST:    w = '{op: UOP_NOP,      cond: COND_FIRST,    target: PC_LOAD};
            PC_PRED:     w = '{op: UOP_PRED,     cond: COND_EZERO,    target: PC_MUL_AA};
            PC_DIV_A:    w = '{op: UOP_DIV,      cond: COND_NONE,     target: PC_IDLE};
            PC_WB_A:     w = '{op: UOP_WB_DIV,   cond: COND_BUSY,     target: PC_WB_A};
            PC_MUL_AA:   w = '{op: UOP_MUL_AA,   cond: COND_NONE,     target: PC_IDLE};
            PC_WB_AA:    w = '{op: UOP_WB_MUL,   cond: COND_BUSY,     target: PC_WB_AA};
            PC_MUL_AC:   w = '{op: UOP_MUL_AC,   cond: COND_NONE,     target: PC_IDLE};
            PC_WB_AC:    w = '{op: UOP_WB_MUL,   cond: COND_BUSY,     target: PC_WB_AC};
            PC_GAIN_BP:  w = '{op: UOP_GAIN_BP,  cond: COND_NONE,     target: PC_IDLE};
            PC_GAIN_DEN: w = '{op: UOP_GAIN_DEN, cond: COND_NONE,     target: PC_IDLE};
            PC_DIV_K:    w = '{op: UOP_DIV,      cond: COND_NONE,     target: PC_IDLE};
            PC_WB_K:     w = '{op: UOP_WB_DIV,   cond: COND_BUSY,     target: PC_WB_K};
            PC_DIFF:     w = '{op: UOP_DIFF,     cond: COND_NONE,     target: PC_IDLE};
            PC_MUL_DK:   w = '{op: UOP_MUL_DK,   cond: COND_NONE,     target: PC_IDLE};
            PC_WB_DK:    w = '{op: UOP_WB_MUL,   cond: COND_BUSY,     target: PC_WB_DK};
            PC_UPDATE:   w = '{op: UOP_UPDATE,   cond: COND_ALWAYS,   target: PC_EMIT};
            PC_LOAD:     w = '{op: UOP_LOAD,     cond: COND_NONE,     target: PC_IDLE};
            PC_EMIT:     w = '{op: UOP_EMIT,     cond: COND_OUT_BUSY, target: PC_EMIT};
            PC_RET:      w = '{op: UOP_NOP,      cond: COND_ALWAYS,   target: PC_IDLE};
            default:     w = '{op: UOP_NOP,      cond: COND_ALWAYS,   target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* src/skt_ifs.sv */
// ----------------------------------------------------------------------------
// skt_ifs
// Valid/ready channel interfaces: sample input, estimate output and the
// offset register write channel.
// ----------------------------------------------------------------------------
interface skt_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] sample_ns;
    logic               restart;

    modport source (output valid, output sample_ns, output restart, input ready);
    modport sink   (input valid, input sample_ns, input restart, output ready);
endinterface

interface skt_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] estimate_ns;

    modport source (output valid, output estimate_ns, input ready);
    modport sink   (input valid, input estimate_ns, output ready);
endinterface

interface skt_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] process_offset;

    modport source (output valid, output process_offset, input ready);
    modport sink   (input valid, input process_offset, output ready);
endinterface

/* src/skt_mul.sv */
// ----------------------------------------------------------------------------
// skt_mul
// Multi-cycle 64x64 fixed-point multiplier: four 32x32 partial products,
// result shifted down by FRAC_BITS and saturated to 64 bits.
// ----------------------------------------------------------------------------
module skt_mul
    import skt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic [63:0] result
);

    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sh_reg, sh_next;
    logic         pp_vld_reg, pp_vld_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [127:0] acc_reg, acc_next;
    logic         busy_reg, busy_next;

    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [1:0]   op_sh;
    logic         ovf;

    // partial product selection
    always_comb
    begin
        op_a  = a_reg[31:0];
        op_b  = b_reg[31:0];
        op_sh = 2'd0;
        case (cnt_reg[1:0])
            2'd0:
            begin
                op_a  = a_reg[31:0];
                op_b  = b_reg[31:0];
                op_sh = 2'd0;
            end
            2'd1:
            begin
                op_a  = a_reg[31:0];
                op_b  = b_reg[63:32];
                op_sh = 2'd1;
            end
            2'd2:
            begin
                op_a  = a_reg[63:32];
                op_b  = b_reg[31:0];
                op_sh = 2'd1;
            end
            default:
            begin
                op_a  = a_reg[63:32];
                op_b  = b_reg[63:32];
                op_sh = 2'd2;
            end
        endcase
    end

    // multiply one partial product, accumulate the previous one
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        pp_next     = pp_reg;
        sh_next     = sh_reg;
        pp_vld_next = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        busy_next   = busy_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            cnt_next  = 3'd0;
            acc_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_next     = 64'(op_a) * 64'(op_b);
                sh_next     = op_sh;
                pp_vld_next = 1'b1;
            end
            if (pp_vld_reg)
            begin
                acc_next = acc_reg + ({64'd0, pp_reg} << {sh_reg, 5'd0});
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            busy_reg   <= busy_next;
            pp_vld_reg <= pp_vld_next;
            cnt_reg    <= cnt_next;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    // scale down and saturate
    assign ovf    = |acc_reg[127:64+FRAC_BITS];
    assign result = ovf ? {64{1'b1}} : acc_reg[64+FRAC_BITS-1:FRAC_BITS];
    assign busy   = busy_reg;

endmodule

/* src/skt_div.sv */
// ----------------------------------------------------------------------------
// skt_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRAC_BITS / den)
// saturated to 64 bits. The divisor is never zero.
// ----------------------------------------------------------------------------
module skt_div
    import skt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        busy,
    output logic [63:0] result
);

    localparam int QW    = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    logic [QW-1:0]    q_reg, q_next;
    logic [63:0]      rem_reg, rem_next;
    logic [63:0]      den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [64:0]      trial;
    logic [64:0]      diff;
    logic             ge;

    // one restoring step
    assign trial = {rem_reg, q_reg[QW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = {num, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[QW-2:0], ge};
            rem_next = ge ? diff[63:0] : trial[63:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // quotient and remainder registers
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // saturate a quotient that does not fit 64 bits
    assign result = (|q_reg[QW-1:64]) ? {64{1'b1}} : q_reg[63:0];
    assign busy   = busy_reg;

endmodule

/* src/skt_seq.sv */
// ----------------------------------------------------------------------------
// skt_seq
// Microcode sequencer: step counter, control word rom and conditional jumps.
// ----------------------------------------------------------------------------
module skt_seq
    import skt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    pc_t  pc_reg, pc_next;
    ctl_t word;
    logic take;

    assign word = ucode(pc_reg);

    // jump condition decode
    always_comb
    begin
        take = 1'b0;
        unique case (word.cond)
            COND_NONE:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_IN:    take = !stat.in_fire;
            COND_FIRST:    take = stat.first;
            COND_EZERO:    take = stat.ezero;
            COND_BUSY:     take = stat.busy;
            COND_OUT_BUSY: take = stat.out_busy;
            default:       take = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        pc_next = take ? word.target : pc_reg + pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctl = word;

endmodule

/* src/scalar_kalman_time_filter.sv */
// Steps: a loading sample (first after reset or restart) passes the first-check, load and emit
// steps after acceptance; a filtered sample runs prediction, divisions, multiplies, update and emit.
// A filtered sample's time is dominated by the one-bit-per-cycle divider, run twice, or once when the estimate is zero.
// Throughput: one sample at a time; the next is taken after the emit and return steps, once the result is loaded
// into the output register, which holds it until the sink takes it.
// Reset: rst_n clears the offset, estimate, covariance and primed flag; no clearing pass.
// ----------------------------------------------------------------------------
// scalar_kalman_time_filter
// One-dimensional Kalman filter over nanosecond time samples, run by a
// microcoded sequencer over a datapath with a shared multiplier and divider.
// ----------------------------------------------------------------------------
module scalar_kalman_time_filter
    import skt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    skt_cfg_if.sink   cfg,
    skt_in_if.sink    sample,
    skt_out_if.source result
);

    localparam logic [63:0] ONE_FIX  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] CVAR     = 64'd100 << FRAC_BITS;
    localparam logic [31:0] COV_INIT = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    // state and working registers
    logic [31:0] offset_reg, offset_next;
    logic [63:0] est_reg, est_next;
    logic [31:0] cov_reg, cov_next;
    logic        primed_reg, primed_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_est_reg, out_est_next;
    logic [63:0] y_reg, y_next;
    logic        restart_reg, restart_next;
    logic [63:0] bx_reg, bx_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] a_reg, a_next;
    logic        dneg_reg, dneg_next;

    ctl_t        ctl;
    stat_t       stat;

    logic        in_fire;
    logic        out_busy;
    logic        mul_start, mul_busy;
    logic [63:0] mul_a, mul_b, mul_res;
    logic        div_start, div_busy;
    logic [63:0] div_res;

    // prediction terms
    logic [63:0] o64, s64, nmag, emag, bx_pred;
    logic        ne, no, ns, ovf, nneg, ezero;
    // gain and update terms
    logic [64:0] bp_sum;
    logic [63:0] bp;
    logic        y_ge;
    logic [63:0] dmag;
    logic [38:0] cp;
    logic [31:0] cov_sat;

    // sequencer
    skt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // shared multiplier
    skt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .busy   (mul_busy),
        .result (mul_res)
    );

    // shared divider
    skt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num_reg),
        .den    (den_reg),
        .busy   (div_busy),
        .result (div_res)
    );

    // handshakes
    assign sample.ready = (ctl.op == UOP_ACCEPT);
    assign in_fire      = sample.valid && sample.ready;
    assign out_busy     = out_valid_reg && !result.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.estimate_ns = out_est_reg;

    // status for jumps
    assign ezero         = (est_reg == 64'd0);
    assign stat.in_fire  = in_fire;
    assign stat.first    = !primed_reg || restart_reg;
    assign stat.ezero    = ezero;
    assign stat.busy     = mul_busy || div_busy;
    assign stat.out_busy = out_busy;

    // unit operand selection
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = a_reg;
        mul_b     = a_reg;
        case (ctl.op)
            UOP_MUL_AA:
            begin
                mul_start = 1'b1;
            end
            UOP_MUL_AC:
            begin
                mul_start = 1'b1;
                mul_b     = {32'd0, cov_reg};
            end
            UOP_MUL_DK:
            begin
                mul_start = 1'b1;
                mul_a     = num_reg;
            end
            UOP_DIV:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // prediction: bX = e + o saturated (zero when e is zero), |e + o| and |e|
    assign o64  = {{32{offset_reg[31]}}, offset_reg};
    assign s64  = est_reg + o64;
    assign ne   = est_reg[63];
    assign no   = o64[63];
    assign ns   = s64[63];
    assign ovf  = (ne == no) && (ns != ne);
    assign nneg = ovf ? ne : ns;
    assign nmag = nneg ? (64'd0 - s64) : s64;
    assign emag = ne ? (64'd0 - est_reg) : est_reg;
    assign bx_pred = ezero ? 64'd0 : (ovf ? (ne ? TOP_BIT : MAX_POS) : s64);

    // gain numerator: t + 100, saturated to the positive range
    assign bp_sum = {1'b0, a_reg} + {1'b0, CVAR};
    assign bp     = (bp_sum[64] || bp_sum[63]) ? MAX_POS : bp_sum[63:0];

    // innovation and new covariance
    assign y_ge    = $signed(y_reg) >= $signed(bx_reg);
    assign dmag    = y_ge ? (y_reg - bx_reg) : (bx_reg - y_reg);
    assign cp      = 39'(a_reg[31:0]) * 39'd100;
    assign cov_sat = (|cp[38:32]) ? 32'hFFFF_FFFF : cp[31:0];

    // datapath writes per micro-operation
    always_comb
    begin
        offset_next    = offset_reg;
        est_next       = est_reg;
        cov_next       = cov_reg;
        primed_next    = primed_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_est_next   = out_est_reg;
        y_next         = y_reg;
        restart_next   = restart_reg;
        bx_next        = bx_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        a_next         = a_reg;
        dneg_next      = dneg_reg;

        if (cfg.valid && cfg.ready)
        begin
            offset_next = cfg.process_offset;
        end

        unique case (ctl.op) inside
            UOP_ACCEPT:
            begin
                if (in_fire)
                begin
                    y_next       = sample.sample_ns;
                    restart_next = sample.restart;
                end
            end
            UOP_LOAD:
            begin
                est_next    = y_reg;
                cov_next    = COV_INIT;
                primed_next = 1'b1;
            end
            UOP_PRED:
            begin
                bx_next  = bx_pred;
                num_next = nmag;
                den_next = emag;
                a_next   = ONE_FIX;
            end
            UOP_WB_DIV:
            begin
                if (!div_busy)
                begin
                    a_next = div_res;
                end
            end
            UOP_WB_MUL:
            begin
                if (!mul_busy)
                begin
                    a_next = mul_res;
                end
            end
            UOP_GAIN_BP:
            begin
                num_next = bp;
            end
            UOP_GAIN_DEN:
            begin
                den_next = num_reg + CVAR;
            end
            UOP_DIFF:
            begin
                dneg_next = !y_ge;
                num_next  = dmag;
                cov_next  = cov_sat;
            end
            UOP_UPDATE:
            begin
                est_next = dneg_reg ? (bx_reg - a_reg) : (bx_reg + a_reg);
            end
            UOP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_est_next   = est_reg;
                end
            end
            UOP_NOP, UOP_DIV, UOP_MUL_AA, UOP_MUL_AC, UOP_MUL_DK:
            begin
                a_next = a_reg;
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    // filter state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            est_reg       <= '0;
            cov_reg       <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            est_reg       <= est_next;
            cov_reg       <= cov_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        out_est_reg <= out_est_next;
        y_reg       <= y_next;
        restart_reg <= restart_next;
        bx_reg      <= bx_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        a_reg       <= a_next;
        dneg_reg    <= dneg_next;
    end

    // multiplier and divider never run together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    // one word at a time: no accept straight after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("second sample accepted while one is in work");

    // emit step presents the current estimate
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == UOP_EMIT && !out_busy) |=>
            (result.valid && result.estimate_ns == $past(est_reg)))
        else $error("result word does not match estimate");

    // load step primes the filter with the sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == UOP_LOAD) |=> (primed_reg && est_reg == $past(y_reg)))
        else $error("load did not prime the estimate");

endmodule
